[rtl/sorter_cycle_controller_defines.svh]
// Assertion macros for the sorter cycle controller.
`ifndef SORTER_CYCLE_CONTROLLER_DEFINES_SVH
`define SORTER_CYCLE_CONTROLLER_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define SCC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define SCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/scc_pkg.sv]
package scc_pkg;

  // Cycle phases
  typedef enum logic [1:0] {
    PH_ARMED    = 2'd0,
    PH_SETTLING = 2'd1,
    PH_AWAIT    = 2'd2,
    PH_COOLDOWN = 2'd3
  } phase_t;

  // Transaction modes
  localparam logic [1:0] MODE_SCAN   = 2'd0;
  localparam logic [1:0] MODE_SORT   = 2'd1;
  localparam logic [1:0] MODE_REJECT = 2'd2;

  localparam logic [1:0] BIN_PAPER   = 2'd0;
  localparam logic [1:0] BIN_PLASTIC = 2'd1;
  localparam logic [1:0] BIN_VINYL   = 2'd2;

  // Display messages
  localparam logic [3:0] MSG_NONE      = 4'd0;
  localparam logic [3:0] MSG_READY     = 4'd1;
  localparam logic [3:0] MSG_DETECTED  = 4'd2;
  localparam logic [3:0] MSG_ANALYZING = 4'd3;
  localparam logic [3:0] MSG_SORTED    = 4'd4;
  localparam logic [3:0] MSG_ONE_ONLY  = 4'd5;

  localparam logic [2:0] VERDICT_NONE     = 3'd0;
  localparam logic [2:0] VERDICT_RETURNED = 3'd4;

  // Register indexes
  localparam logic [2:0] REG_DETECT_ECHO = 3'd0;
  localparam logic [2:0] REG_SETTLE      = 3'd1;
  localparam logic [2:0] REG_COOLDOWN    = 3'd2;
  localparam logic [2:0] REG_TIMEOUT     = 3'd3;
  localparam logic [2:0] REG_BIN0_ANGLE  = 3'd4;
  localparam logic [2:0] REG_BIN1_ANGLE  = 3'd5;
  localparam logic [2:0] REG_BIN2_ANGLE  = 3'd6;

  // Register reset values
  localparam logic [14:0] DETECT_ECHO_RST = 15'd870;
  localparam logic [15:0] SETTLE_RST      = 16'd3000;
  localparam logic [15:0] COOLDOWN_RST    = 16'd2000;
  localparam logic [15:0] TIMEOUT_RST     = 16'd30000;
  localparam logic [7:0]  BIN0_ANGLE_RST  = 8'd0;
  localparam logic [7:0]  BIN1_ANGLE_RST  = 8'd90;
  localparam logic [7:0]  BIN2_ANGLE_RST  = 8'd180;

  localparam logic [7:0]  ANGLE_MAX = 8'd180;

  typedef struct packed {
    logic [14:0] detect_echo_us;
    logic [15:0] settle_time;
    logic [15:0] cool_time;
    logic [15:0] timeout_ms;
    logic [7:0]  bin0_angle;
    logic [7:0]  bin1_angle;
    logic [7:0]  bin2_angle;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic [9:0]         delta_ms;
    logic signed [15:0] echo_a;
    logic signed [15:0] echo_b;
    logic signed [15:0] echo_c;
    logic [1:0]         bin_choice;
    logic [1:0]         reject_reason;
  } item_t;

  typedef struct packed {
    phase_t      phase;
    logic [15:0] elapsed_ms;
    logic [2:0]  verdict;
  } state_t;

  typedef struct packed {
    logic [1:0] phase;
    logic       detect_pulse;
    logic       dispense_pulse;
    logic [7:0] carousel_deg;
    logic [3:0] message;
    logic [2:0] last_outcome;
    logic       answer_timeout;
  } result_t;

endpackage

[rtl/scc_step.sv]
module scc_step import scc_pkg::*; (
  input  cfg_t    cfg,
  input  item_t   item,
  input  state_t  st,
  output state_t  st_nxt,
  output result_t res
);

  logic [16:0]        sum;
  logic [15:0]        elapsed_sat;
  logic signed [15:0] med;
  logic               med_close;
  logic [7:0]         angle_raw;

  // Saturating phase timer advance
  assign sum         = {1'b0, st.elapsed_ms} + {7'd0, item.delta_ms};
  assign elapsed_sat = sum[16] ? 16'hFFFF : sum[15:0];

  // Median of three signed echoes
  always_comb begin
    if ((item.echo_a >= item.echo_b && item.echo_a <= item.echo_c) ||
        (item.echo_a <= item.echo_b && item.echo_a >= item.echo_c)) begin
      med = item.echo_a;
    end else if ((item.echo_b >= item.echo_a && item.echo_b <= item.echo_c) ||
                 (item.echo_b <= item.echo_a && item.echo_b >= item.echo_c)) begin
      med = item.echo_b;
    end else begin
      med = item.echo_c;
    end
  end

  // Positive median under threshold; timeouts are negative and never detect
  assign med_close = (med > 16'sd0) && (med[15:0] < {1'b0, cfg.detect_echo_us});

  // Bin angle lookup
  always_comb begin
    case (item.bin_choice)
      BIN_PAPER:   angle_raw = cfg.bin0_angle;
      BIN_PLASTIC: angle_raw = cfg.bin1_angle;
      BIN_VINYL:   angle_raw = cfg.bin2_angle;
      default:     angle_raw = 8'd0;
    endcase
  end

  // Phase transitions and result fields
  always_comb begin
    st_nxt             = st;
    res                = '0;
    case (item.mode)
      MODE_SCAN: begin
        st_nxt.elapsed_ms = elapsed_sat;
        case (st.phase)
          PH_ARMED: begin
            if (elapsed_sat > cfg.timeout_ms) begin
              res.message       = MSG_READY;
              st_nxt.elapsed_ms = '0;
            end
            // detection wins over refresh
            if (med_close) begin
              res.message       = MSG_DETECTED;
              st_nxt.phase      = PH_SETTLING;
              st_nxt.elapsed_ms = '0;
            end
          end
          PH_SETTLING: begin
            if (elapsed_sat >= cfg.settle_time) begin
              res.detect_pulse  = 1'b1;
              res.message       = MSG_ANALYZING;
              st_nxt.phase      = PH_AWAIT;
              st_nxt.elapsed_ms = '0;
            end
          end
          PH_AWAIT: begin
            if (elapsed_sat > cfg.timeout_ms) begin
              res.answer_timeout = 1'b1;
              res.message        = MSG_READY;
              st_nxt.phase       = PH_ARMED;
              st_nxt.elapsed_ms  = '0;
            end
          end
          default: begin
            if (elapsed_sat >= cfg.cool_time) begin
              res.message       = MSG_READY;
              st_nxt.phase      = PH_ARMED;
              st_nxt.elapsed_ms = '0;
            end
          end
        endcase
      end
      MODE_SORT: begin
        // unknown bin name leaves everything as is
        if (item.bin_choice inside {BIN_PAPER, BIN_PLASTIC, BIN_VINYL}) begin
          res.carousel_deg   = (angle_raw > ANGLE_MAX) ? ANGLE_MAX : angle_raw;
          res.dispense_pulse = 1'b1;
          res.message        = MSG_SORTED;
          st_nxt.verdict     = {1'b0, item.bin_choice} + 3'd1;
          st_nxt.phase       = PH_COOLDOWN;
          st_nxt.elapsed_ms  = '0;
        end
      end
      MODE_REJECT: begin
        res.message       = MSG_ONE_ONLY + {2'b00, item.reject_reason};
        st_nxt.verdict    = VERDICT_RETURNED;
        st_nxt.phase      = PH_COOLDOWN;
        st_nxt.elapsed_ms = '0;
      end
      default: begin
      end
    endcase
    res.phase        = st_nxt.phase;
    res.last_outcome = st_nxt.verdict;
  end

endmodule

[rtl/sorter_cycle_controller.sv]
// Sorter cycle controller: one result transaction per input transaction, one transaction
// per clock while the result side does not stall. Each accepted scan, sort or reject
// item is evaluated against the current phase, timer and configuration in a single
// combinational pass and lands in the output register in the next cycle; the next item
// is taken in that same cycle unless the result register is full and stalled.
// Configuration writes take effect at the next clock and are meant to be issued while
// no result is pending.
`include "sorter_cycle_controller_defines.svh"

module sorter_cycle_controller import scc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  // configuration write port
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_mode,
  input  logic [9:0]         in_delta_ms,
  input  logic signed [15:0] in_echo_a,
  input  logic signed [15:0] in_echo_b,
  input  logic signed [15:0] in_echo_c,
  input  logic [1:0]         in_bin_choice,
  input  logic [1:0]         in_reject_reason,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_phase,
  output logic               out_detect_pulse,
  output logic               out_dispense_pulse,
  output logic [7:0]         out_carousel_deg,
  output logic [3:0]         out_message,
  output logic [2:0]         out_last_outcome,
  output logic               out_answer_timeout
);

  cfg_t    cfg_r;
  state_t  st_r;
  state_t  st_nxt;
  item_t   item;
  result_t res_nxt;
  result_t res_r;
  logic    out_valid_r;
  logic    accept;

  assign item = '{mode: in_mode, delta_ms: in_delta_ms, echo_a: in_echo_a,
                  echo_b: in_echo_b, echo_c: in_echo_c, bin_choice: in_bin_choice,
                  reject_reason: in_reject_reason};

  // Take a new transaction unless a finished result is held
  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  scc_step u_step (
    .cfg    (cfg_r),
    .item   (item),
    .st     (st_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.detect_echo_us <= DETECT_ECHO_RST;
      cfg_r.settle_time    <= SETTLE_RST;
      cfg_r.cool_time      <= COOLDOWN_RST;
      cfg_r.timeout_ms     <= TIMEOUT_RST;
      cfg_r.bin0_angle     <= BIN0_ANGLE_RST;
      cfg_r.bin1_angle     <= BIN1_ANGLE_RST;
      cfg_r.bin2_angle     <= BIN2_ANGLE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DETECT_ECHO: cfg_r.detect_echo_us <= cfg_data[14:0];
        REG_SETTLE:      cfg_r.settle_time    <= cfg_data;
        REG_COOLDOWN:    cfg_r.cool_time      <= cfg_data;
        REG_TIMEOUT:     cfg_r.timeout_ms     <= cfg_data;
        REG_BIN0_ANGLE:  cfg_r.bin0_angle     <= cfg_data[7:0];
        REG_BIN1_ANGLE:  cfg_r.bin1_angle     <= cfg_data[7:0];
        REG_BIN2_ANGLE:  cfg_r.bin2_angle     <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // Cycle state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase      <= PH_ARMED;
      st_r.elapsed_ms <= '0;
      st_r.verdict    <= VERDICT_NONE;
      out_valid_r     <= 1'b0;
    end else begin
      if (accept) begin
        st_r        <= st_nxt;
        res_r       <= res_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_phase          = res_r.phase;
  assign out_detect_pulse   = res_r.detect_pulse;
  assign out_dispense_pulse = res_r.dispense_pulse;
  assign out_carousel_deg   = res_r.carousel_deg;
  assign out_message        = res_r.message;
  assign out_last_outcome   = res_r.last_outcome;
  assign out_answer_timeout = res_r.answer_timeout;

  // Checks
  `SCC_ASSERT_SAME(a_dispense_cooldown, out_valid_r && res_r.dispense_pulse,
    res_r.phase == PH_COOLDOWN, "dispense pulse outside cooldown")
  `SCC_ASSERT_SAME(a_detect_await, out_valid_r && res_r.detect_pulse,
    res_r.phase == PH_AWAIT && res_r.message == MSG_ANALYZING, "detect pulse mismatch")
  `SCC_ASSERT_SAME(a_timeout_armed, out_valid_r && res_r.answer_timeout,
    res_r.phase == PH_ARMED && res_r.message == MSG_READY, "timeout not rearmed")
  `SCC_ASSERT_NEXT(a_accept_result, accept, out_valid_r, "accepted item gave no result")

endmodule

[test/tb_top.sv]
module tb_top;
  import scc_pkg::*;

  localparam logic [1:0]         MODE_IDLE      = 2'd3;
  localparam logic [1:0]         BIN_UNKNOWN    = 2'd3;
  localparam logic signed [15:0] ECHO_TIMEOUT   = -16'sd1;
  localparam int                 WATCHDOG_LIMIT = 2000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_mode = '0;
  logic [9:0]         in_delta_ms = '0;
  logic signed [15:0] in_echo_a = '0;
  logic signed [15:0] in_echo_b = '0;
  logic signed [15:0] in_echo_c = '0;
  logic [1:0]         in_bin_choice = '0;
  logic [1:0]         in_reject_reason = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         out_phase;
  logic               out_detect_pulse;
  logic               out_dispense_pulse;
  logic [7:0]         out_carousel_deg;
  logic [3:0]         out_message;
  logic [2:0]         out_last_outcome;
  logic               out_answer_timeout;

  sorter_cycle_controller u_dut (.*);

  always #10 clk = ~clk;

  // Predicted controller state and register copy
  cfg_t        cfg_shadow = '{DETECT_ECHO_RST, SETTLE_RST, COOLDOWN_RST, TIMEOUT_RST,
                              BIN0_ANGLE_RST, BIN1_ANGLE_RST, BIN2_ANGLE_RST};
  phase_t      run_phase = PH_ARMED;
  logic [15:0] run_ms = '0;
  logic [2:0]  run_verdict = VERDICT_NONE;

  item_t   item_backlog[$];
  result_t due_results[$];
  int      n_queued = 0;
  int      n_accepted = 0;
  int      mismatches = 0;
  int      idle_cycles = 0;
  logic    in_taken = 1'b0;
  int      in_gap = 0;
  int      in_calm = 0;
  int      stall_left = 0;
  int      out_calm = 0;
  item_t   next_item;

  function automatic logic signed [15:0] median3(logic signed [15:0] a,
                                                 logic signed [15:0] b,
                                                 logic signed [15:0] c);
    logic signed [15:0] lo, hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    return (c < lo) ? lo : ((c > hi) ? hi : c);
  endfunction

  function automatic void enter_phase(phase_t p);
    run_phase = p;
    run_ms = '0;
  endfunction

  // Expected result of one transaction; updates the predicted state
  function automatic result_t advance_cycle(item_t it);
    result_t            r;
    logic [16:0]        sum;
    logic signed [15:0] m;
    logic [7:0]         ang;
    r = '0;
    case (it.mode)
      MODE_SCAN: begin
        sum = {1'b0, run_ms} + 17'(it.delta_ms);
        run_ms = sum[16] ? 16'hFFFF : sum[15:0];
        case (run_phase)
          PH_ARMED: begin
            m = median3(it.echo_a, it.echo_b, it.echo_c);
            if (run_ms > cfg_shadow.timeout_ms) begin
              r.message = MSG_READY;
              run_ms = '0;
            end
            // a detection overrides the periodic refresh
            if (m > 0 && $unsigned(m) < {1'b0, cfg_shadow.detect_echo_us}) begin
              r.message = MSG_DETECTED;
              enter_phase(PH_SETTLING);
            end
          end
          PH_SETTLING: begin
            if (run_ms >= cfg_shadow.settle_time) begin
              r.detect_pulse = 1'b1;
              r.message = MSG_ANALYZING;
              enter_phase(PH_AWAIT);
            end
          end
          PH_AWAIT: begin
            if (run_ms > cfg_shadow.timeout_ms) begin
              r.answer_timeout = 1'b1;
              r.message = MSG_READY;
              enter_phase(PH_ARMED);
            end
          end
          default: begin
            if (run_ms >= cfg_shadow.cool_time) begin
              r.message = MSG_READY;
              enter_phase(PH_ARMED);
            end
          end
        endcase
      end
      MODE_SORT: begin
        if (it.bin_choice != BIN_UNKNOWN) begin
          case (it.bin_choice)
            BIN_PAPER:   ang = cfg_shadow.bin0_angle;
            BIN_PLASTIC: ang = cfg_shadow.bin1_angle;
            default:     ang = cfg_shadow.bin2_angle;
          endcase
          r.carousel_deg = (ang > ANGLE_MAX) ? ANGLE_MAX : ang;
          r.dispense_pulse = 1'b1;
          r.message = MSG_SORTED;
          run_verdict = 3'(it.bin_choice) + 3'd1;
          enter_phase(PH_COOLDOWN);
        end
      end
      MODE_REJECT: begin
        r.message = MSG_ONE_ONLY + 4'(it.reject_reason);
        run_verdict = VERDICT_RETURNED;
        enter_phase(PH_COOLDOWN);
      end
      default: ;
    endcase
    r.phase = run_phase;
    r.last_outcome = run_verdict;
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Mostly short gaps, a few long ones, and now and then a stretch with none
  function automatic int pick_gap(inout int calm);
    int unsigned r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r == 0) begin
      calm = $urandom_range(30, 120);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Input driver: next transaction once the current one is taken
  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap--;
      end else if (item_backlog.size() != 0) begin
        next_item = item_backlog.pop_front();
        in_mode <= next_item.mode;
        in_delta_ms <= next_item.delta_ms;
        in_echo_a <= next_item.echo_a;
        in_echo_b <= next_item.echo_b;
        in_echo_c <= next_item.echo_c;
        in_bin_choice <= next_item.bin_choice;
        in_reject_reason <= next_item.reject_reason;
        in_valid <= 1'b1;
        in_gap = pick_gap(in_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      stall_left = pick_gap(out_calm);
    end
  end

  // Monitor: register writes, result checks, predictions, watchdog
  always @(posedge clk) begin
    result_t got, want;
    item_t   seen;
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DETECT_ECHO: cfg_shadow.detect_echo_us = cfg_data[14:0];
          REG_SETTLE:      cfg_shadow.settle_time = cfg_data;
          REG_COOLDOWN:    cfg_shadow.cool_time = cfg_data;
          REG_TIMEOUT:     cfg_shadow.timeout_ms = cfg_data;
          REG_BIN0_ANGLE:  cfg_shadow.bin0_angle = cfg_data[7:0];
          REG_BIN1_ANGLE:  cfg_shadow.bin1_angle = cfg_data[7:0];
          REG_BIN2_ANGLE:  cfg_shadow.bin2_angle = cfg_data[7:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got.phase = out_phase;
        got.detect_pulse = out_detect_pulse;
        got.dispense_pulse = out_dispense_pulse;
        got.carousel_deg = out_carousel_deg;
        got.message = out_message;
        got.last_outcome = out_last_outcome;
        got.answer_timeout = out_answer_timeout;
        if (due_results.size() == 0) begin
          $display("%0t unexpected result: expected none, actual phase %0d message %0d",
                   $time, got.phase, got.message);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          check_field("phase", want.phase, got.phase);
          check_field("detect_pulse", want.detect_pulse, got.detect_pulse);
          check_field("dispense_pulse", want.dispense_pulse, got.dispense_pulse);
          check_field("carousel_deg", want.carousel_deg, got.carousel_deg);
          check_field("message", want.message, got.message);
          check_field("last_outcome", want.last_outcome, got.last_outcome);
          check_field("answer_timeout", want.answer_timeout, got.answer_timeout);
        end
      end
      in_taken = in_valid && !in_stall;
      if (in_taken) begin
        seen.mode = in_mode;
        seen.delta_ms = in_delta_ms;
        seen.echo_a = in_echo_a;
        seen.echo_b = in_echo_b;
        seen.echo_c = in_echo_c;
        seen.bin_choice = in_bin_choice;
        seen.reject_reason = in_reject_reason;
        due_results.push_back(advance_cycle(seen));
        n_accepted++;
      end
      if (in_taken || (out_valid && !out_stall) || (!in_valid && due_results.size() == 0))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  function automatic item_t mk_item(logic [1:0] mode, int delta, int a, int b, int c,
                                    logic [1:0] bin, logic [1:0] why);
    item_t it;
    it.mode = mode;
    it.delta_ms = 10'(delta);
    it.echo_a = 16'(a);
    it.echo_b = 16'(b);
    it.echo_c = 16'(c);
    it.bin_choice = bin;
    it.reject_reason = why;
    return it;
  endfunction

  // Scan tick; the command fields are don't-care and get random content
  function automatic item_t scan(int delta, int a, int b, int c);
    return mk_item(MODE_SCAN, delta, a, b, c, 2'($urandom), 2'($urandom));
  endfunction

  function automatic logic signed [15:0] far_echo();
    int unsigned r, lim;
    r = $urandom_range(0, 9);
    lim = (cfg_shadow.detect_echo_us > 30000) ? 30000 : cfg_shadow.detect_echo_us;
    if (r < 3) return ECHO_TIMEOUT;
    if (r < 8) return 16'($urandom_range(lim, 30000));
    return 16'($urandom);
  endfunction

  function automatic logic signed [15:0] close_echo();
    if (cfg_shadow.detect_echo_us <= 1) return far_echo();
    return 16'($urandom_range(1, cfg_shadow.detect_echo_us - 1));
  endfunction

  function automatic int scans_for(logic [15:0] ms);
    int n;
    n = ms / 750 + $urandom_range(0, 2);
    return (n > 100) ? 100 : n;
  endfunction

  task automatic push_item(item_t it);
    item_backlog.push_back(it);
    n_queued++;
  endtask

  task automatic push_scans(int n);
    repeat (n) push_item(scan($urandom_range(500, 1000), far_echo(), close_echo(),
                              far_echo()));
  endtask

  // One pass of the machine: absent, detect, settle, answer or timeout, cooldown
  task automatic push_sort_cycle();
    int          n;
    int unsigned r;
    logic [1:0]  bin;
    n = $urandom_range(0, 3);
    repeat (n) push_item(scan($urandom_range(0, 1000), far_echo(), far_echo(), far_echo()));
    case ($urandom_range(0, 2))
      0: push_item(scan($urandom_range(0, 1000), close_echo(), close_echo(), far_echo()));
      1: push_item(scan($urandom_range(0, 1000), far_echo(), close_echo(), close_echo()));
      default: push_item(scan($urandom_range(0, 1000), close_echo(), far_echo(),
                              close_echo()));
    endcase
    push_scans(scans_for(cfg_shadow.settle_time) + 1);
    r = $urandom_range(0, 19);
    if (r < 13) begin
      bin = ($urandom_range(0, 7) == 0) ? BIN_UNKNOWN : 2'($urandom_range(0, 2));
      push_item(mk_item(MODE_SORT, $urandom_range(0, 1023), $urandom, $urandom, $urandom,
                        bin, 2'($urandom)));
    end else if (r < 17) begin
      push_item(mk_item(MODE_REJECT, $urandom_range(0, 1023), $urandom, $urandom, $urandom,
                        2'($urandom), 2'($urandom)));
    end else begin
      // no answer: let the wait run out
      push_scans(scans_for(cfg_shadow.timeout_ms) + 2);
    end
    push_scans(scans_for(cfg_shadow.cool_time));
  endtask

  task automatic push_random_traffic(int target);
    int stop_at;
    stop_at = n_queued + target;
    while (n_queued < stop_at) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 4))
          push_item(mk_item(2'($urandom), $urandom_range(0, 1023), $urandom, $urandom,
                            $urandom, 2'($urandom), 2'($urandom)));
      end else begin
        push_sort_cycle();
      end
    end
  endtask

  task automatic write_reg(logic [2:0] idx, int value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 16'(value);
  endtask

  task automatic apply_settings(int det, int settle, int cool, int tmo,
                                int b0, int b1, int b2);
    write_reg(REG_DETECT_ECHO, det);
    write_reg(REG_SETTLE, settle);
    write_reg(REG_COOLDOWN, cool);
    write_reg(REG_TIMEOUT, tmo);
    write_reg(REG_BIN0_ANGLE, b0);
    write_reg(REG_BIN1_ANGLE, b1);
    write_reg(REG_BIN2_ANGLE, b2);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (n_accepted != n_queued || due_results.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at reset settings
    push_item(scan(0, ECHO_TIMEOUT, ECHO_TIMEOUT, ECHO_TIMEOUT));
    push_item(scan(1000, 30000, 30000, -32768));
    push_item(scan(1000, 869, 1, 30000));            // median just under threshold
    push_item(scan(1000, 100, 100, 100));            // settling ignores echoes
    push_item(scan(1000, 30000, 0, 5));
    push_item(scan(1000, 500, 500, 500));            // settle reached
    push_item(mk_item(MODE_SORT, 0, 0, 0, 0, BIN_PAPER, 2'd0));
    push_item(scan(1000, 1, 1, 1));
    push_item(scan(1000, 1, 1, 1));                  // cooldown done
    push_item(mk_item(MODE_REJECT, 0, 0, 0, 0, 2'd0, 2'd0));
    push_item(mk_item(MODE_REJECT, 0, 0, 0, 0, 2'd0, 2'd1));
    push_item(mk_item(MODE_REJECT, 0, 0, 0, 0, 2'd0, 2'd2));
    push_item(mk_item(MODE_REJECT, 0, 0, 0, 0, 2'd0, 2'd3));
    push_item(mk_item(MODE_SORT, 1000, 0, 0, 0, BIN_UNKNOWN, 2'd3));
    push_item(mk_item(MODE_IDLE, 1000, 10, 10, 10, 2'd3, 2'd3));
    push_item(mk_item(MODE_SORT, 0, 0, 0, 0, BIN_PLASTIC, 2'd0));
    push_item(mk_item(MODE_SORT, 0, 0, 0, 0, BIN_VINYL, 2'd0));
    push_item(scan(1000, 870, 870, 870));
    push_item(scan(1000, 870, 870, 870));            // back to armed
    push_item(scan(0, 870, 870, 870));               // equal to threshold, no detect
    push_item(scan(0, 0, 0, 500));                   // zero median
    push_item(scan(0, -5, -5, 100));                 // negative median
    push_item(scan(1000, -32768, 32767, 400));       // detect with extreme neighbors
    push_item(mk_item(MODE_REJECT, 1000, 0, 0, 0, 2'd0, 2'd1));
    push_random_traffic(80);
    wait_drained();

    // Zero settle and cooldown, shortest timeout, two bin angles above range
    apply_settings(2000, 0, 0, 1, 181, 255, 45);
    push_random_traffic(90);
    wait_drained();

    apply_settings(30000, 1500, 800, 4000, 180, 0, 90);
    push_random_traffic(90);
    wait_drained();

    // Top of the documented ranges
    apply_settings(32767, 60000, 60000, 60000, 0, 180, 179);
    push_random_traffic(110);
    wait_drained();

    // Full-scale timers saturate the phase timer; zero threshold never detects
    apply_settings(0, 65535, 65535, 65535, 128, 1, 200);
    push_random_traffic(60);
    wait_drained();

    apply_settings($urandom_range(1, 30000), $urandom_range(0, 6000),
                   $urandom_range(0, 4000), $urandom_range(1, 8000),
                   $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
    push_random_traffic(80);
    wait_drained();

    if (mismatches == 0 && due_results.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
